@@ hdl/mseu_pkg.sv @@
// ----------------------------------------------------------------------------
// mseu_pkg
// Types and constants shared by the execute unit and its register file.
// ----------------------------------------------------------------------------
package mseu_pkg;

	localparam logic [1:0] CMD_EXEC    = 2'd0;
	localparam logic [1:0] CMD_LOAD    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;
	localparam logic [1:0] CMD_NOP     = 2'd3;

	localparam logic [2:0] MEM_NONE  = 3'd0;
	localparam logic [2:0] MEM_RDW   = 3'd1;
	localparam logic [2:0] MEM_RDB   = 3'd2;
	localparam logic [2:0] MEM_WRB   = 3'd3;
	localparam logic [2:0] MEM_WRW   = 3'd4;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_WAIT    = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_SYSCALL = 2'd3;

	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_REGIMM  = 6'd1;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_BGTZ    = 6'd7;
	localparam logic [5:0] OP_ADDIU   = 6'd9;
	localparam logic [5:0] OP_SLTIU   = 6'd11;
	localparam logic [5:0] OP_ORI     = 6'd13;
	localparam logic [5:0] OP_LUI     = 6'd15;
	localparam logic [5:0] OP_BNEL    = 6'd21;
	localparam logic [5:0] OP_BGTZL   = 6'd23;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_LBU     = 6'd36;
	localparam logic [5:0] OP_SB      = 6'd40;
	localparam logic [5:0] OP_SW      = 6'd43;

	localparam logic [5:0] FN_SLL     = 6'd0;
	localparam logic [5:0] FN_SRL     = 6'd2;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_MFHI    = 6'd16;
	localparam logic [5:0] FN_MFLO    = 6'd18;
	localparam logic [5:0] FN_DIVU    = 6'd27;
	localparam logic [5:0] FN_ADD     = 6'd32;
	localparam logic [5:0] FN_ADDU    = 6'd33;
	localparam logic [5:0] FN_AND     = 6'd36;
	localparam logic [5:0] FN_XOR     = 6'd38;
	localparam logic [5:0] FN_SLTU    = 6'd43;

	localparam logic [4:0] RT_BGEZ    = 5'd1;
	localparam logic [4:0] REG_SP     = 5'd29;

	localparam logic [31:0] START_PC_RST = 32'h0890_0050;
	localparam logic [31:0] START_SP_RST = 32'h09FF_C000;
	localparam logic [31:0] JUMP_REGION  = 32'hF000_0000;

	typedef struct packed {
		logic        en;
		logic [4:0]  addr;
		logic [31:0] data;
	} rf_wr_t;

	typedef struct packed {
		logic [31:0] fetch_pc;
		logic [2:0]  mem_op;
		logic [31:0] mem_addr;
		logic [31:0] mem_wdata;
		logic        reg_written;
		logic [4:0]  reg_write_index;
		logic [31:0] reg_write_value;
		logic [1:0]  status;
		logic [19:0] syscall_code;
	} res_t;

endpackage

@@ hdl/mips_subset_execute_unit.sv @@
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// Executes a subset of a 32-bit MIPS integer core, one instruction per item,
// with the general registers held in a synchronous memory.
// ----------------------------------------------------------------------------
// Channel  | Handshake             | Payload
// command  | cmd_valid, cmd_stall  | command, instr_word, load_data
// result   | res_valid, res_stall  | fetch_pc .. syscall_code
// config   | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// The register file memory is read as an item is accepted; the item is then
// executed and written back in the execute state. DIVU with a nonzero divisor
// also runs the bit-serial divider. One item is in flight at a time; a result
// waits in the output register while the next item is read. A stalled result
// holds the block in its execute state. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  command,
	input  logic [31:0] instr_word,
	input  logic [31:0] load_data,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] fetch_pc,
	output logic [2:0]  mem_op,
	output logic [31:0] mem_addr,
	output logic [31:0] mem_wdata,
	output logic        reg_written,
	output logic [4:0]  reg_write_index,
	output logic [31:0] reg_write_value,
	output logic [1:0]  status,
	output logic [19:0] syscall_code
);
	import mseu_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_RESP} state_t;

	state_t      state_q;
	logic [31:0] start_pc_q, start_sp_q;
	logic [31:0] pc_q, hi_q, lo_q, btgt_q;
	logic        bpend_q, lpend_q, lbyte_q;
	logic [4:0]  ldest_q;
	logic [1:0]  cmd_q;
	logic [31:0] iw_q, ld_q;
	res_t        res_q, pend_q, res;
	logic        res_valid_q, out_free, accept;
	rf_wr_t      rf_wr;
	logic        rf_clear;
	logic [31:0] vs, vt;
	logic        div_start, div_done;
	logic [31:0] div_quo, div_rem;

	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sa;
	logic [31:0] imm, simm, link, btgt, addr, seq, wval, ldv;
	logic [63:0] rot;
	logic        unknown, taken, annul, wr, restart, commit_state, is_div;
	logic [4:0]  widx;
	logic [31:0] n_pc;

	assign cfg_ready = 1'b1;
	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign out_free  = !res_valid_q || !res_stall;

	mseu_regfile u_rf (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (rf_clear),
		.clear_sp (start_sp_q),
		.rd_en    (accept),
		.ra       (instr_word[25:21]),
		.rb       (instr_word[20:16]),
		.wr       (rf_wr),
		.qa       (vs),
		.qb       (vt)
	);

	mseu_divu u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (vs),
		.divisor  (vt),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_comb begin
		op   = iw_q[31:26];
		rs   = iw_q[25:21];
		rt   = iw_q[20:16];
		rd   = iw_q[15:11];
		sa   = iw_q[10:6];
		fn   = iw_q[5:0];
		imm  = {16'd0, iw_q[15:0]};
		simm = {{16{iw_q[15]}}, iw_q[15:0]};
		link = pc_q + 32'd4;
		btgt = link + {simm[29:0], 2'b00};
		addr = vs + simm;
		seq  = bpend_q ? btgt_q : link;
		rot  = {vt, vt} >> sa;
		ldv  = lbyte_q ? {24'd0, ld_q[7:0]} : ld_q;
		unknown = 1'b0;
		taken   = 1'b0;
		annul   = 1'b0;
		wr      = 1'b0;
		widx    = rd;
		wval    = '0;
		is_div  = 1'b0;
		restart = 1'b0;
		commit_state = 1'b0;
		n_pc    = pc_q;
		res     = '0;
		res.fetch_pc = pc_q;
		case (cmd_q)
			CMD_RESTART: begin
				restart = 1'b1;
				res.fetch_pc = start_pc_q;
			end
			CMD_LOAD: begin
				wr   = lpend_q;
				widx = ldest_q;
				wval = ldv;
			end
			CMD_EXEC: begin
				if (lpend_q) begin
					res.status = ST_WAIT;
				end else begin
					case (op)
						OP_SPECIAL: begin
							case (fn)
								FN_SLL: begin
									wr = 1'b1; wval = vt << sa;
								end
								FN_SRL: begin
									if (rs == 5'd0) begin
										wr = 1'b1; wval = vt >> sa;
									end else if (rs == 5'd1) begin
										wr = 1'b1; wval = rot[31:0];
									end else begin
										unknown = 1'b1;
									end
								end
								FN_SYSCALL: begin
									res.status       = ST_SYSCALL;
									res.syscall_code = iw_q[25:6];
								end
								FN_MFHI: begin
									wr = 1'b1; wval = hi_q;
								end
								FN_MFLO: begin
									wr = 1'b1; wval = lo_q;
								end
								FN_DIVU: is_div = (vt != 32'd0);
								FN_ADD, FN_ADDU: begin
									wr = 1'b1; wval = vs + vt;
								end
								FN_AND: begin
									wr = 1'b1; wval = vs & vt;
								end
								FN_XOR: begin
									wr = 1'b1; wval = vs ^ vt;
								end
								FN_SLTU: begin
									wr = 1'b1; wval = {31'd0, vs < vt};
								end
								default: unknown = 1'b1;
							endcase
						end
						OP_REGIMM: begin
							if (rt == RT_BGEZ) begin
								taken = !vs[31];
							end else begin
								unknown = 1'b1;
							end
						end
						OP_J: begin
							taken = 1'b1;
							btgt  = (link & JUMP_REGION) | {4'd0, iw_q[25:0], 2'b00};
						end
						OP_BNE:  taken = (vs != vt);
						OP_BGTZ: taken = (vs != 32'd0) && !vs[31];
						OP_ADDIU: begin
							wr = 1'b1; widx = rt; wval = vs + simm;
						end
						OP_SLTIU: begin
							wr = 1'b1; widx = rt; wval = {31'd0, vs < simm};
						end
						OP_ORI: begin
							wr = 1'b1; widx = rt; wval = vs | imm;
						end
						OP_LUI: begin
							wr = 1'b1; widx = rt; wval = {iw_q[15:0], 16'd0};
						end
						OP_BNEL: begin
							taken = (vs != vt);
							annul = !taken;
						end
						OP_BGTZL: begin
							taken = (vs != 32'd0) && !vs[31];
							annul = !taken;
						end
						OP_LW, OP_LBU: begin
							res.mem_op   = (op == OP_LW) ? MEM_RDW : MEM_RDB;
							res.mem_addr = addr;
							res.status   = ST_WAIT;
						end
						OP_SB: begin
							res.mem_op    = MEM_WRB;
							res.mem_addr  = addr;
							res.mem_wdata = {24'd0, vt[7:0]};
						end
						OP_SW: begin
							res.mem_op    = MEM_WRW;
							res.mem_addr  = addr;
							res.mem_wdata = vt;
						end
						default: unknown = 1'b1;
					endcase
					if (unknown) begin
						res        = '0;
						res.fetch_pc = pc_q;
						res.status = ST_UNKNOWN;
						wr         = 1'b0;
						is_div     = 1'b0;
					end else begin
						commit_state = 1'b1;
						n_pc = annul ? seq + 32'd4 : seq;
						res.fetch_pc = n_pc;
					end
				end
			end
			default: ;
		endcase
		if (wr && widx != 5'd0) begin
			res.reg_written     = 1'b1;
			res.reg_write_index = widx;
			res.reg_write_value = wval;
		end
	end

	logic fire;
	assign fire      = (state_q == S_EXEC) && (is_div || out_free);
	assign div_start = fire && is_div;
	assign rf_clear  = fire && restart;
	assign rf_wr.en   = fire && res.reg_written;
	assign rf_wr.addr = res.reg_write_index;
	assign rf_wr.data = res.reg_write_value;

	always_ff @(posedge clk) begin
		if (accept) begin
			iw_q <= instr_word;
			ld_q <= load_data;
		end
		if (div_start) begin
			pend_q <= res;
		end
		if (fire && !is_div) begin
			res_q <= res;
		end else if (state_q == S_RESP && out_free) begin
			res_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= CMD_NOP;
			start_pc_q  <= START_PC_RST;
			start_sp_q  <= START_SP_RST;
			pc_q        <= START_PC_RST;
			hi_q        <= '0;
			lo_q        <= '0;
			bpend_q     <= 1'b0;
			btgt_q      <= '0;
			lpend_q     <= 1'b0;
			ldest_q     <= '0;
			lbyte_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index) begin
					start_sp_q <= cfg_data;
				end else begin
					start_pc_q <= cfg_data;
				end
			end
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= command;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						if (restart) begin
							pc_q    <= start_pc_q;
							hi_q    <= '0;
							lo_q    <= '0;
							bpend_q <= 1'b0;
							btgt_q  <= '0;
							lpend_q <= 1'b0;
							ldest_q <= '0;
							lbyte_q <= 1'b0;
						end
						if (cmd_q == CMD_LOAD) begin
							lpend_q <= 1'b0;
						end
						if (commit_state) begin
							pc_q    <= n_pc;
							bpend_q <= taken;
							if (taken) begin
								btgt_q <= btgt;
							end
							if (op == OP_LW || op == OP_LBU) begin
								lpend_q <= 1'b1;
								ldest_q <= rt;
								lbyte_q <= (op == OP_LBU);
							end
						end
						if (is_div) begin
							state_q <= S_DIV;
						end else begin
							res_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						lo_q    <= div_quo;
						hi_q    <= div_rem;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid       = res_valid_q;
	assign fetch_pc        = res_q.fetch_pc;
	assign mem_op          = res_q.mem_op;
	assign mem_addr        = res_q.mem_addr;
	assign mem_wdata       = res_q.mem_wdata;
	assign reg_written     = res_q.reg_written;
	assign reg_write_index = res_q.reg_write_index;
	assign reg_write_value = res_q.reg_write_value;
	assign status          = res_q.status;
	assign syscall_code    = res_q.syscall_code;

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(rf_wr.en && rf_wr.addr == 5'd0))
		else $error("register zero written");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_EXEC || $past(state_q) == S_RESP)
		else $error("result raised outside execute or response");

endmodule

@@ hdl/mseu_regfile.sv @@
// ----------------------------------------------------------------------------
// mseu_regfile
// General register file: a synchronous memory with two registered read ports
// and one write port. Valid bits make unwritten entries read as their reset
// value, with the stack pointer taken at reset or restart.
// ----------------------------------------------------------------------------
module mseu_regfile (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic [31:0]       clear_sp,
	input  logic              rd_en,
	input  logic [4:0]        ra,
	input  logic [4:0]        rb,
	input  mseu_pkg::rf_wr_t  wr,
	output logic [31:0]       qa,
	output logic [31:0]       qb
);
	import mseu_pkg::*;

	logic [31:0] mem [32];
	logic [31:0] valid_q;
	logic [31:0] sp_q;
	logic [31:0] mem_qa_q, mem_qb_q, alt_qa_q, alt_qb_q;
	logic        use_a_q, use_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			mem_qa_q <= mem[ra];
			mem_qb_q <= mem[rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			sp_q     <= START_SP_RST;
			use_a_q  <= 1'b0;
			use_b_q  <= 1'b0;
			alt_qa_q <= '0;
			alt_qb_q <= '0;
		end else begin
			if (clear) begin
				valid_q <= '0;
				sp_q    <= clear_sp;
			end else if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				use_a_q  <= valid_q[ra];
				use_b_q  <= valid_q[rb];
				alt_qa_q <= (ra == REG_SP) ? sp_q : 32'd0;
				alt_qb_q <= (rb == REG_SP) ? sp_q : 32'd0;
			end
		end
	end

	assign qa = use_a_q ? mem_qa_q : alt_qa_q;
	assign qb = use_b_q ? mem_qb_q : alt_qb_q;

endmodule

@@ hdl/mseu_divu.sv @@
// ----------------------------------------------------------------------------
// mseu_divu
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mseu_divu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quo,
	output logic [31:0] rem
);
	logic [31:0] q_q, r_q, d_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] r_sh, diff;

	assign r_sh = {r_q, q_q[31]};
	assign diff = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				r_q <= diff[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= r_sh[31:0];
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MIPS subset execute unit. A directed table of
// instruction words is run first, then constrained-by-hand random programs
// under several start configurations, with random idling on both channels.
// Each result is compared field by field with the predictor or a typed row.
// ----------------------------------------------------------------------------
module testbench;
	import mseu_pkg::*;

	localparam logic       CFG_START_PC = 1'b0;
	localparam logic       CFG_START_SP = 1'b1;
	localparam logic [5:0] OP_UNDEF     = 6'd63;
	localparam logic [5:0] FN_UNDEF     = 6'd63;
	localparam logic [4:0] RT_UNDEF     = 5'd2;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         RANDOM_ITEMS = 170;

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] iw;
		logic [31:0] ld;
		bit          typed;
		res_t        want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [1:0]  command = CMD_NOP;
	logic [31:0] instr_word = '0;
	logic [31:0] load_data = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [31:0] fetch_pc;
	logic [2:0]  mem_op;
	logic [31:0] mem_addr;
	logic [31:0] mem_wdata;
	logic        reg_written;
	logic [4:0]  reg_write_index;
	logic [31:0] reg_write_value;
	logic [1:0]  status;
	logic [19:0] syscall_code;

	mips_subset_execute_unit dut (.*);

	// Predictor state.
	logic [31:0] gpr [32];
	logic [31:0] pc, hi_word, lo_word, branch_dest, start_pc_cfg, start_sp_cfg;
	bit          branch_armed, load_waiting, load_byte;
	logic [4:0]  load_reg;

	res_t        expected_results [$];
	int          errors = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;
	row_t        dir_rows [$];

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[mips_subset_execute_unit] ERROR");
			$finish;
		end
	end

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch on %s: got 0x%08h, expected 0x%08h", field, got, want);
		errors++;
	endtask

	function automatic void core_restart();
		for (int i = 0; i < 32; i++) gpr[i] = '0;
		gpr[REG_SP] = start_sp_cfg;
		pc = start_pc_cfg;
		hi_word = '0;
		lo_word = '0;
		branch_armed = 1'b0;
		branch_dest = '0;
		load_waiting = 1'b0;
		load_reg = '0;
		load_byte = 1'b0;
	endfunction

	function automatic res_t predict_result(logic [1:0] cmd, logic [31:0] iw, logic [31:0] ld);
		res_t        r;
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd, sa, widx;
		logic [31:0] simm, vs, vt, link, tgt, seq_pc, wval, v;
		bit          unk, taken, annul, wr;
		r = '0;
		op = iw[31:26];
		fn = iw[5:0];
		rs = iw[25:21];
		rt = iw[20:16];
		rd = iw[15:11];
		sa = iw[10:6];
		simm = {{16{iw[15]}}, iw[15:0]};
		vs = gpr[rs];
		vt = gpr[rt];
		link = pc + 32'd4;
		tgt = link + (simm << 2);
		seq_pc = branch_armed ? branch_dest : link;
		unk = 1'b0; taken = 1'b0; annul = 1'b0; wr = 1'b0;
		widx = '0; wval = '0;
		if (cmd == CMD_RESTART) begin
			core_restart();
			r.fetch_pc = pc;
			return r;
		end
		if (cmd == CMD_LOAD) begin
			if (load_waiting) begin
				v = load_byte ? {24'd0, ld[7:0]} : ld;
				if (load_reg != 0) begin
					gpr[load_reg] = v;
					r.reg_written = 1'b1;
					r.reg_write_index = load_reg;
					r.reg_write_value = v;
				end
				load_waiting = 1'b0;
			end
			r.fetch_pc = pc;
			return r;
		end
		if (cmd == CMD_NOP) begin
			r.fetch_pc = pc;
			return r;
		end
		if (load_waiting) begin
			r.fetch_pc = pc;
			r.status = ST_WAIT;
			return r;
		end
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_SLL: begin wr = 1; widx = rd; wval = vt << sa; end
					FN_SRL: begin
						if (rs == 0) begin
							wr = 1; widx = rd; wval = vt >> sa;
						end else if (rs == 1) begin
							wr = 1; widx = rd;
							wval = (sa != 0) ? ((vt >> sa) | (vt << (6'd32 - sa))) : vt;
						end else unk = 1;
					end
					FN_SYSCALL: begin r.status = ST_SYSCALL; r.syscall_code = iw[25:6]; end
					FN_MFHI: begin wr = 1; widx = rd; wval = hi_word; end
					FN_MFLO: begin wr = 1; widx = rd; wval = lo_word; end
					FN_DIVU: begin
						if (vt != 0) begin
							lo_word = vs / vt;
							hi_word = vs % vt;
						end
					end
					FN_ADD, FN_ADDU: begin wr = 1; widx = rd; wval = vs + vt; end
					FN_AND: begin wr = 1; widx = rd; wval = vs & vt; end
					FN_XOR: begin wr = 1; widx = rd; wval = vs ^ vt; end
					FN_SLTU: begin wr = 1; widx = rd; wval = (vs < vt) ? 32'd1 : 32'd0; end
					default: unk = 1;
				endcase
			end
			OP_REGIMM: begin
				if (rt == RT_BGEZ) taken = !vs[31];
				else unk = 1;
			end
			OP_J: begin
				taken = 1;
				tgt = {link[31:28], iw[25:0], 2'b00};
			end
			OP_BNE: taken = (vs != vt);
			OP_BGTZ: taken = (vs != 0) && !vs[31];
			OP_ADDIU: begin wr = 1; widx = rt; wval = vs + simm; end
			OP_SLTIU: begin wr = 1; widx = rt; wval = (vs < simm) ? 32'd1 : 32'd0; end
			OP_ORI: begin wr = 1; widx = rt; wval = vs | {16'd0, iw[15:0]}; end
			OP_LUI: begin wr = 1; widx = rt; wval = {iw[15:0], 16'd0}; end
			OP_BNEL: begin taken = (vs != vt); annul = !taken; end
			OP_BGTZL: begin taken = (vs != 0) && !vs[31]; annul = !taken; end
			OP_LW, OP_LBU: begin
				r.mem_op = (op == OP_LW) ? MEM_RDW : MEM_RDB;
				r.mem_addr = vs + simm;
				r.status = ST_WAIT;
				load_waiting = 1'b1;
				load_reg = rt;
				load_byte = (op == OP_LBU);
			end
			OP_SB: begin r.mem_op = MEM_WRB; r.mem_addr = vs + simm; r.mem_wdata = {24'd0, vt[7:0]}; end
			OP_SW: begin r.mem_op = MEM_WRW; r.mem_addr = vs + simm; r.mem_wdata = vt; end
			default: unk = 1;
		endcase
		if (unk) begin
			r = '0;
			r.fetch_pc = pc;
			r.status = ST_UNKNOWN;
			return r;
		end
		if (wr && widx != 0) begin
			gpr[widx] = wval;
			r.reg_written = 1'b1;
			r.reg_write_index = widx;
			r.reg_write_value = wval;
		end
		branch_armed = taken;
		if (taken) branch_dest = tgt;
		pc = annul ? seq_pc + 32'd4 : seq_pc;
		r.fetch_pc = pc;
		return r;
	endfunction

	function automatic logic [31:0] r_word(logic [4:0] rs, rt, rd, sa, logic [5:0] fn);
		return {OP_SPECIAL, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic row_t row(logic [1:0] cmd, logic [31:0] iw, logic [31:0] ld);
		return row_t'{cmd: cmd, iw: iw, ld: ld, typed: 1'b0, want: '0};
	endfunction

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
	endfunction

	function automatic logic [31:0] random_instr();
		logic [15:0] imm;
		logic [5:0]  ops [15];
		logic [5:0]  fns [11];
		imm = 16'($urandom);
		ops = '{OP_REGIMM, OP_J, OP_BNE, OP_BGTZ, OP_ADDIU, OP_SLTIU, OP_ORI, OP_LUI,
			OP_BNEL, OP_BGTZL, OP_LW, OP_LBU, OP_SB, OP_SW, OP_LUI};
		fns = '{FN_SLL, FN_SRL, FN_SYSCALL, FN_MFHI, FN_MFLO, FN_DIVU, FN_ADD, FN_ADDU,
			FN_AND, FN_XOR, FN_SLTU};
		case ($urandom_range(0, 9))
			0: return $urandom;
			1, 2, 3, 4:
				return r_word(pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
					fns[$urandom_range(0, 10)]) |
					(($urandom_range(0, 7) == 0) ? {6'd0, 5'($urandom), 21'd0} : 32'd0);
			5: return i_word(OP_REGIMM, pick_reg(),
				($urandom_range(0, 5) == 0) ? 5'($urandom) : RT_BGEZ, imm);
			default: return i_word(ops[$urandom_range(0, 14)], pick_reg(), pick_reg(), imm);
		endcase
	endfunction

	task automatic send_item(input logic [1:0] c, input logic [31:0] iw, input logic [31:0] ld,
			input bit typed, input res_t want);
		res_t p;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= c;
		instr_word <= iw;
		load_data <= ld;
		do @(posedge clk); while (cmd_stall);
		p = predict_result(c, iw, ld);
		expected_results.push_back(typed ? want : p);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The caller lowers cfg_valid after the last write of a burst.
	task automatic write_cfg(input logic idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_START_PC) start_pc_cfg = value;
		else start_sp_cfg = value;
	endtask

	always @(posedge clk) begin
		res_t got, want;
		if (res_valid && !res_stall) begin
			got = '{fetch_pc, mem_op, mem_addr, mem_wdata, reg_written, reg_write_index,
				reg_write_value, status, syscall_code};
			if (expected_results.size() == 0) begin
				report("unexpected item fetch_pc", got.fetch_pc, '0);
			end else begin
				want = expected_results.pop_front();
				if (got.fetch_pc !== want.fetch_pc) report("fetch_pc", got.fetch_pc, want.fetch_pc);
				if (got.mem_op !== want.mem_op) report("mem_op", 32'(got.mem_op), 32'(want.mem_op));
				if (got.mem_addr !== want.mem_addr) report("mem_addr", got.mem_addr, want.mem_addr);
				if (got.mem_wdata !== want.mem_wdata) report("mem_wdata", got.mem_wdata, want.mem_wdata);
				if (got.reg_written !== want.reg_written)
					report("reg_written", 32'(got.reg_written), 32'(want.reg_written));
				if (got.reg_write_index !== want.reg_write_index)
					report("reg_write_index", 32'(got.reg_write_index), 32'(want.reg_write_index));
				if (got.reg_write_value !== want.reg_write_value)
					report("reg_write_value", got.reg_write_value, want.reg_write_value);
				if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
				if (got.syscall_code !== want.syscall_code)
					report("syscall_code", 32'(got.syscall_code), 32'(want.syscall_code));
			end
		end
	end

	initial begin
		forever begin
			if (quiet) begin
				res_stall <= 1'b0;
				@(posedge clk);
			end else begin
				res_stall <= ($urandom_range(0, 2) == 0);
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [31:0] cfg_pc [4];
		logic [31:0] cfg_sp [4];
		res_t        w;
		logic [1:0]  c;
		int          r;
		start_pc_cfg = START_PC_RST;
		start_sp_cfg = START_SP_RST;
		core_restart();

		w = '0;
		w.fetch_pc = START_PC_RST;
		dir_rows.push_back(row_t'{cmd: CMD_NOP, iw: '0, ld: '0, typed: 1'b1, want: w});
		w.fetch_pc = START_PC_RST + 32'd4;
		w.reg_written = 1'b1;
		w.reg_write_index = 5'd1;
		w.reg_write_value = 32'hFFFF_0000;
		dir_rows.push_back(row_t'{cmd: CMD_EXEC, iw: i_word(OP_LUI, 5'd0, 5'd1, 16'hFFFF),
			ld: '0, typed: 1'b1, want: w});
		w = '0;
		w.fetch_pc = START_PC_RST + 32'd4;
		w.status = ST_UNKNOWN;
		dir_rows.push_back(row_t'{cmd: CMD_EXEC, iw: {OP_UNDEF, 26'h3FF_FFFF}, ld: '0,
			typed: 1'b1, want: w});
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_ORI, 5'd1, 5'd1, 16'hFFFF), '0));
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_ADDIU, 5'd0, 5'd2, 16'h7FFF), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd1, 5'd2, 5'd3, 5'd0, FN_ADD), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd1, 5'd1, 5'd4, 5'd0, FN_ADDU), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd1, 5'd2, 5'd5, 5'd0, FN_AND), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd1, 5'd2, 5'd6, 5'd0, FN_XOR), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd2, 5'd1, 5'd7, 5'd0, FN_SLTU), '0));
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_SLTIU, 5'd2, 5'd8, 16'h8000), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd0, 5'd1, 5'd9, 5'd31, FN_SLL), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd1, 5'd2, 5'd10, 5'd4, FN_SRL), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd2, 5'd2, 5'd11, 5'd4, FN_SRL), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd1, 5'd0, 5'd0, 5'd0, FN_DIVU), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd1, 5'd2, 5'd0, 5'd0, FN_DIVU), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd0, 5'd0, 5'd12, 5'd0, FN_MFHI), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd0, 5'd0, 5'd13, 5'd0, FN_MFLO), '0));
		dir_rows.push_back(row(CMD_EXEC, {OP_SPECIAL, 20'hFFFFF, FN_SYSCALL}, '0));
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_LW, REG_SP, 5'd14, 16'h8000), '0));
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_SW, 5'd1, 5'd1, 16'h7FFF), '0));
		dir_rows.push_back(row(CMD_LOAD, '0, 32'hFFFF_FFFF));
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_LBU, 5'd1, 5'd0, 16'hFFFF), '0));
		dir_rows.push_back(row(CMD_LOAD, '0, 32'h1234_5678));
		dir_rows.push_back(row(CMD_LOAD, '0, 32'hAAAA_5555));
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_SB, 5'd2, 5'd1, 16'h8000), '0));
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_BNE, 5'd1, 5'd0, 16'hFFFE), '0));
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_BGTZ, 5'd1, 5'd0, 16'h0004), '0));
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_BGTZL, 5'd1, 5'd0, 16'h0004), '0));
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_BNEL, 5'd1, 5'd2, 16'h0010), '0));
		dir_rows.push_back(row(CMD_EXEC, {OP_J, 26'h3FF_FFFF}, '0));
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_REGIMM, 5'd0, RT_BGEZ, 16'h0008), '0));
		dir_rows.push_back(row(CMD_EXEC, i_word(OP_REGIMM, 5'd0, RT_UNDEF, 16'h0008), '0));
		dir_rows.push_back(row(CMD_EXEC, r_word(5'd0, 5'd0, 5'd0, 5'd0, FN_UNDEF), '0));
		dir_rows.push_back(row(CMD_RESTART, '0, '0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].cmd, dir_rows[i].iw, dir_rows[i].ld, dir_rows[i].typed,
				dir_rows[i].want);

		cfg_pc = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, START_PC_RST};
		cfg_sp = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_cfg(CFG_START_PC, cfg_pc[ph]);
			write_cfg(CFG_START_SP, cfg_sp[ph]);
			cfg_valid <= 1'b0;
			send_item(CMD_RESTART, $urandom, $urandom, 1'b0, '0);
			for (int n = 0; n < RANDOM_ITEMS; n++) begin
				if (ph == 3 && n > RANDOM_ITEMS - 60) quiet = 1'b1;
				r = $urandom_range(0, 99);
				if (load_waiting) begin
					c = (r < 85) ? CMD_LOAD : (r < 93) ? CMD_EXEC : CMD_NOP;
				end else begin
					c = (r < 88) ? CMD_EXEC : (r < 93) ? CMD_NOP : (r < 97) ? CMD_LOAD : CMD_RESTART;
				end
				send_item(c, (c == CMD_EXEC) ? random_instr() : $urandom, $urandom, 1'b0, '0);
			end
		end
		drain();
		if (errors == 0) begin
			$display("[mips_subset_execute_unit] OK");
		end else begin
			$display("[mips_subset_execute_unit] ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/mseu_pkg.sv
hdl/mseu_regfile.sv
hdl/mseu_divu.sv
hdl/mips_subset_execute_unit.sv
tb/sv/testbench.sv
